/* hw/rtl/ovl_pkg.sv */
package ovl_pkg;

   // Operation codes carried on req_func
   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_TAIL  = 3'd1,
      FUNC_REMOVE     = 3'd2,
      FUNC_CONTAINS   = 3'd3,
      FUNC_CLEAR      = 3'd4
   } func_type;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 5;

   // Per-cell update broadcast along the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_PREV,
      CELL_TAKE_NEXT,
      CELL_LOAD_TAIL
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

/* hw/rtl/ovl_cell.sv */
module ovl_cell
   import ovl_pkg::*;
#(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 5
) (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] prev_data,
   input  logic signed [VALUE_W-1:0] next_data,
   input  logic                      match_in,
   output logic                      match_out,
   output logic signed [VALUE_W-1:0] data
);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;
   logic                      occupied;

   // Cell holds a live entry when its place lies below the count
   assign occupied  = count > CNT_W'(INDEX);
   // Carry the first-match flag toward the tail
   assign match_out = match_in | (occupied & (data_ff == cmd.value));
   assign data      = data_ff;

   // Pick the next entry value
   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_TAKE_PREV: data_in = prev_data;
         CELL_TAKE_NEXT: if (match_out) data_in = next_data;
         CELL_LOAD_TAIL: if (count == CNT_W'(INDEX)) data_in = cmd.value;
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* hw/rtl/ordered_value_list_core.sv */
// A result is registered and appears in the cycle after its request transfer.
// Throughput: one item per cycle; req_ready stays high while the result register
// is empty or being drained in the same cycle.
// Cycle time is set by the first-match flag rippling through the cell chain.
// Reset clears the entry count and the result valid; cell contents stay
// undefined until written.
module ordered_value_list_core
   import ovl_pkg::*;
#(
   parameter int unsigned LIST_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_func,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic                      rsp_rejected,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

   logic                      req_xfer;
   logic                      full;
   logic                      any_match;
   cell_cmd_type              cmd;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_found_ff;
   logic                      rsp_found_in;
   logic                      rsp_rejected_ff;
   logic                      rsp_rejected_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic [COUNT_W-1:0]        rsp_count_in;
   logic signed [VALUE_W-1:0] cell_data [LIST_DEPTH];
   logic                      match_chain [LIST_DEPTH+1];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(LIST_DEPTH);
   assign match_chain[0] = 1'b0;
   assign any_match = match_chain[LIST_DEPTH];

   // Build the cell command and the new count
   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.value = req_value;
      count_in  = count_ff;
      rsp_found_in    = 1'b0;
      rsp_rejected_in = 1'b0;
      if (req_xfer) begin
         unique case (req_func)
            FUNC_PUSH_FRONT, FUNC_PUSH_TAIL: begin
               if (full) begin
                  rsp_rejected_in = 1'b1;
               end else begin
                  cmd.op   = (req_func == FUNC_PUSH_FRONT) ? CELL_TAKE_PREV : CELL_LOAD_TAIL;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FUNC_REMOVE: begin
               cmd.op       = CELL_TAKE_NEXT;
               rsp_found_in = any_match;
               if (any_match) count_in = count_ff - CNT_W'(1);
            end
            FUNC_CONTAINS: rsp_found_in = any_match;
            FUNC_CLEAR:    count_in = '0;
            default:       count_in = count_ff;
         endcase
      end
   end

   // Hold or refresh the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_found_ff    <= rsp_found_in;
         rsp_rejected_ff <= rsp_rejected_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   // Row of storage cells, front entry in cell 0
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_data;
      logic signed [VALUE_W-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_data = req_value;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_inner
         assign next_data = cell_data[i+1];
      end

      ovl_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .prev_data (prev_data),
         .next_data (next_data),
         .match_in  (match_chain[i]),
         .match_out (match_chain[i+1]),
         .data      (cell_data[i])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_rejected = rsp_rejected_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

/* hw/rtl/ovl_checker.sv */
module ovl_checker
   import ovl_pkg::*;
#(
   parameter int unsigned LIST_DEPTH = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [2:0]                req_func,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic                      rsp_rejected,
   input logic [COUNT_W-1:0]        rsp_count
);

   logic req_xfer;
   logic is_push;

   assign req_xfer = req_valid && req_ready;
   assign is_push  = (req_func == FUNC_PUSH_FRONT) || (req_func == FUNC_PUSH_TAIL);

   // Every transfer yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("no result after request transfer");

   // A stalled result holds its payload
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count)
         && $stable(rsp_found) && $stable(rsp_rejected))
      else $error("stalled result changed");

   // Clear empties the list with no flags
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_func == FUNC_CLEAR |=> rsp_count == '0 && !rsp_found && !rsp_rejected)
      else $error("clear gave a wrong result");

   // Pushes never report a match
   a_push_no_found: assert property (@(posedge clock) disable iff (reset)
      req_xfer && is_push |=> !rsp_found)
      else $error("push reported found");

   // A refused push only happens at full capacity
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_count == COUNT_W'(LIST_DEPTH) && !rsp_found)
      else $error("push refused below capacity");

endmodule

bind ordered_value_list_core ovl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ovl_checker (.*);
